// ===== rtl/arpr_pkg.sv =====
package arpr_pkg;

  localparam int unsigned ArpMinLen   = 14 + 28;
  localparam int unsigned ReplyLen    = 60;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [5:0] PosMax       = 6'd63;
  localparam logic [5:0] PosHdrFirst  = 6'd12;
  localparam logic [5:0] PosHdrLast   = 6'd21;
  localparam logic [5:0] PosMacFirst  = 6'd22;
  localparam logic [5:0] PosMacLast   = 6'd27;
  localparam logic [5:0] PosIpFirst   = 6'd28;
  localparam logic [5:0] PosIpLast    = 6'd31;
  localparam logic [5:0] PosTgtFirst  = 6'd38;
  localparam logic [5:0] PosTgtLast   = 6'd41;
  localparam logic [5:0] PosFinal     = 6'(ArpMinLen - 1);
  localparam logic [5:0] ReplyLastPos = 6'(ReplyLen - 1);

  localparam logic [31:0] MyIpv4Reset = 32'h0A00_020F;

  typedef enum logic [1:0] {
    CfgEnable = 2'd0,
    CfgMyMac  = 2'd1,
    CfgMyIpv4 = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] HdrExpect [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };

  localparam logic [7:0] ReplyFixed [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  typedef struct packed {
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
  } job_t;

  // byte 0 is the most significant one
  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] idx);
    logic [2:0] sh;
    sh = 3'(3'd5 - idx);
    return mac[{sh, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [1:0] idx);
    return ip[{~idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== rtl/arpr_front.sv =====
module arpr_front
  import arpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        enable_i,
  input  logic [31:0] my_ipv4_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [5:0]  pos_q, pos_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [47:0] smac_q, smac_d;
  logic [31:0] sip_q, sip_d;
  logic        accept;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    pos_d    = pos_q;
    hdr_ok_d = hdr_ok_q;
    smac_d   = smac_q;
    sip_d    = sip_q;
    if (pos_q >= PosHdrFirst && pos_q <= PosHdrLast) begin
      if (rx_byte_i != HdrExpect[4'(pos_q - PosHdrFirst)]) begin
        hdr_ok_d = 1'b0;
      end
    end else if (pos_q >= PosMacFirst && pos_q <= PosMacLast) begin
      smac_d = {smac_q[39:0], rx_byte_i};
    end else if (pos_q >= PosIpFirst && pos_q <= PosIpLast) begin
      sip_d = {sip_q[23:0], rx_byte_i};
    end else if (pos_q >= PosTgtFirst && pos_q <= PosTgtLast) begin
      if (rx_byte_i != ip_byte(my_ipv4_i, 2'(pos_q - PosTgtFirst))) begin
        hdr_ok_d = 1'b0;
      end
    end
    if (pos_q != PosMax) begin
      pos_d = pos_q + 6'd1;
    end
  end

  assign push_o = accept & rx_last_i & enable_i & hdr_ok_d & (pos_q >= PosFinal);
  assign job_o  = '{sender_mac: smac_d, sender_ip: sip_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_ok_q <= 1'b1;
      smac_q   <= '0;
      sip_q    <= '0;
    end else if (accept) begin
      smac_q <= smac_d;
      sip_q  <= sip_d;
      if (rx_last_i) begin
        pos_q    <= '0;
        hdr_ok_q <= 1'b1;
      end else begin
        pos_q    <= pos_d;
        hdr_ok_q <= hdr_ok_d;
      end
    end
  end

endmodule

// ===== rtl/arpr_fifo.sv =====
module arpr_fifo
  import arpr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            jobs_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = jobs_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      jobs_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("job count out of range");
`endif

endmodule

// ===== rtl/arpr_back.sv =====
module arpr_back
  import arpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [47:0] my_mac_i,
  input  logic [31:0] my_ipv4_i,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o
);

  logic [5:0] k_q;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       olast_q;
  logic [7:0] byte_d;
  logic       load;
  logic       at_end;

  always_comb begin
    case (k_q) inside
      [6'd0:6'd5]:   byte_d = mac_byte(job_i.sender_mac, k_q[2:0]);
      [6'd6:6'd11]:  byte_d = mac_byte(my_mac_i, 3'(k_q - 6'd6));
      [6'd12:6'd21]: byte_d = ReplyFixed[4'(k_q - 6'd12)];
      [6'd22:6'd27]: byte_d = mac_byte(my_mac_i, 3'(k_q - 6'd22));
      [6'd28:6'd31]: byte_d = ip_byte(my_ipv4_i, k_q[1:0]);
      [6'd32:6'd37]: byte_d = mac_byte(job_i.sender_mac, k_q[2:0]);
      [6'd38:6'd41]: byte_d = ip_byte(job_i.sender_ip, 2'(k_q - 6'd38));
      default:       byte_d = 8'h00;
    endcase
  end

  assign at_end = (k_q == ReplyLastPos);
  assign load   = job_valid_i & (~ovalid_q | out_ready_i);
  assign pop_o  = load & at_end;

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= byte_d;
      olast_q <= at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        k_q      <= at_end ? '0 : k_q + 6'd1;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign tx_byte_o   = obyte_q;
  assign tx_last_o   = olast_q;

endmodule

// ===== rtl/arp_request_responder.sv =====
// ARP request responder.
// s_axis: received Ethernet frame, one byte per item (tdata = rx_byte,
//   tlast = rx_last on the final byte). m_axis: 60-byte ARP reply, one byte
//   per item (tdata = tx_byte, tlast = tx_last on byte 59).
// cfg: register writes (index 0 enable, 1 my_mac, 2 my_ipv4), always ready;
//   other indexes are dropped.
// The receive side takes one byte per cycle unless the job queue is full.
//   When the final byte of a valid request is taken, a job (sender MAC and
//   IPv4) is registered in a two-entry queue, then the first reply byte in
//   the output register. Replies stream at one byte per cycle while
//   m_axis_tready is high, set by the reply generator's single byte counter.
// s_axis_tready drops only while the job queue is full; m_axis stalls hold
//   the output register and, through the queue, eventually the receive side.
// Reset: queue empty, parser at offset 0, enable 0, my_mac 0,
//   my_ipv4 10.0.2.15. No clearing pass is needed.
module arp_request_responder
  import arpr_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] tx_byte
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic        enable_q;
  logic [47:0] my_mac_q;
  logic [31:0] my_ipv4_q;
  logic        push, full, job_valid, pop;
  job_t        job_in, job_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      my_mac_q  <= '0;
      my_ipv4_q <= MyIpv4Reset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgEnable: enable_q  <= cfg_data_i[0];
        CfgMyMac:  my_mac_q  <= cfg_data_i;
        CfgMyIpv4: my_ipv4_q <= cfg_data_i[31:0];
        default:   ;
      endcase
    end
  end

  arpr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .my_ipv4_i    (my_ipv4_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .rx_byte_i    (s_axis_tdata),
    .rx_last_i    (s_axis_tlast),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  arpr_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (pop),
    .job_o   (job_head)
  );

  arpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .my_mac_i    (my_mac_q),
    .my_ipv4_i   (my_ipv4_q),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .tx_byte_o   (m_axis_tdata),
    .tx_last_o   (m_axis_tlast)
  );

endmodule
